FILE: rtl/strict_priority_packet_queue_core_defines.svh
// Assertion macros shared by the strict-priority packet queue RTL.
`ifndef STRICT_PRIORITY_PACKET_QUEUE_CORE_DEFINES_SVH
`define STRICT_PRIORITY_PACKET_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Types and constants shared by the strict-priority packet queue modules.
package spq_pkg;

  localparam int TAG_W      = 16;
  localparam int BYTES_W    = 14;
  localparam int PRI_W      = 4;
  localparam int LIMIT_W    = 24;
  localparam int THRESH_W   = 12;
  localparam int TOTAL_W    = 28;
  localparam int OUT_BAND_W = 3;
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int FIFO_SHIFT = 3;

  localparam logic               MODE_RESET   = 1'b1;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 24'd36000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd22;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_TOTAL_DROP = 3'd1,
    ST_BAND_DROP  = 3'd2,
    ST_RING_FULL  = 3'd3,
    ST_DEQUEUED   = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
  } pkt_t;

  typedef struct packed {
    logic                priority_mode;
    logic [LIMIT_W-1:0]  byte_limit;
    logic [THRESH_W-1:0] mark_threshold;
  } cfg_t;

endpackage

FILE: rtl/spq_front.sv
// Input stage: accepts items, maps priority to band and holds them for the queue.
module spq_front #(
  parameter int BANDS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [spq_pkg::TAG_W-1:0]     packet_tag,
  input  logic [spq_pkg::BYTES_W-1:0]   packet_bytes,
  input  logic [spq_pkg::PRI_W-1:0]     pkt_prio,
  output logic                          push_valid,
  input  logic                          push_ready,
  output spq_pkg::pkt_t                 push_pkt,
  output logic [$clog2(BANDS)-1:0]      push_band
);

  localparam int BW  = $clog2(BANDS);
  localparam int PW1 = spq_pkg::PRI_W + 1;

  logic           vld;
  logic [PW1-1:0] pri_m1;
  logic [PW1-1:0] pri_sat;
  logic [BW-1:0]  band;

  always_comb begin
    pri_m1  = (pkt_prio == '0) ? '0 : ({1'b0, pkt_prio} - PW1'(1));
    pri_sat = (pri_m1 > PW1'(BANDS - 1)) ? PW1'(BANDS - 1) : pri_m1;
    band    = cfg.priority_mode ? pri_sat[BW-1:0] : '0;
  end

  assign in_ready   = !vld || push_ready;
  assign push_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld            <= 1'b1;
      push_pkt.op    <= spq_pkg::op_t'(opcode);
      push_pkt.tag   <= packet_tag;
      push_pkt.bytes <= packet_bytes;
      push_band      <= band;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
  end

endmodule

FILE: rtl/spq_fifo.sv
// Short queue that decouples the input stage from the execution stage.
module spq_fifo #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int QPW = $clog2(spq_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(spq_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [spq_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   cnt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt != QCW'(spq_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPW'(spq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(spq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/spq_back.sv
// Execution stage: band rings, byte and packet accounting, descriptor store, result register.
module spq_back #(
  parameter int BANDS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spq_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  spq_pkg::pkt_t                  q_pkt,
  input  logic [$clog2(BANDS)-1:0]       q_band,
  output logic                           out_valid,
  input  logic                           out_ready,
  output spq_pkg::status_t               status,
  output logic                           ecn_marked,
  output logic [spq_pkg::TAG_W-1:0]      out_tag,
  output logic [spq_pkg::BYTES_W-1:0]    out_bytes,
  output logic [spq_pkg::OUT_BAND_W-1:0] out_band
);

  localparam int BW    = $clog2(BANDS);
  localparam int PW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int SLOTS = BANDS * RING_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int PKW   = $clog2(SLOTS + 1);
  localparam int EW    = (PKW + 1 > spq_pkg::THRESH_W) ? PKW + 1 : spq_pkg::THRESH_W;
  localparam int SW    = spq_pkg::TOTAL_W + 1;
  localparam int DW    = spq_pkg::TAG_W + spq_pkg::BYTES_W;

  typedef enum logic {
    S_EVAL,
    S_COMMIT
  } state_t;

  state_t state;

  logic [BANDS-1:0][PW-1:0]               head;
  logic [BANDS-1:0][PW-1:0]               tail;
  logic [BANDS-1:0][CW-1:0]               count;
  logic [BANDS-1:0][spq_pkg::TOTAL_W-1:0] band_bytes;
  logic [spq_pkg::TOTAL_W-1:0]            total_bytes;
  logic [PKW-1:0]                         total_packets;

  logic [DW-1:0] store [SLOTS];
  logic [DW-1:0] rd_data;

  logic [BW-1:0]            deq_band;
  logic                     deq_any;
  logic [BW-1:0]            sel_band;
  logic [PW-1:0]            sel_ptr;
  logic [PW-1:0]            ptr_next;
  logic [AW-1:0]            addr;
  logic [SW-1:0]            limit;
  logic [SW-1:0]            tot_sum;
  logic [SW-1:0]            band_sum;
  logic [EW-1:0]            pk_inc;
  spq_pkg::status_t         eval_status;
  logic                     eval_ecn;

  spq_pkg::op_t                w_op;
  logic [spq_pkg::TAG_W-1:0]   w_tag;
  logic [spq_pkg::BYTES_W-1:0] w_bytes;
  logic [BW-1:0]               w_band;
  spq_pkg::status_t            w_status;
  logic                        w_ecn;
  logic [AW-1:0]               w_addr;
  logic [PW-1:0]               w_ptr_next;
  logic [CW-1:0]               w_count;
  logic [spq_pkg::TOTAL_W-1:0] w_band_bytes;
  logic [SW-1:0]               w_tot_sum;
  logic [SW-1:0]               w_band_sum;

  logic                        commit_go;
  logic                        enq_ok;
  logic                        deq_ok;
  logic [spq_pkg::BYTES_W-1:0] rd_bytes;
  logic [spq_pkg::TAG_W-1:0]   rd_tag;

  always_comb begin
    deq_band = '0;
    deq_any  = 1'b0;
    for (int b = BANDS - 1; b >= 0; b--) begin
      if (count[b] != '0) begin
        deq_band = BW'(b);
        deq_any  = 1'b1;
      end
    end
  end

  always_comb begin
    sel_band = (q_pkt.op == spq_pkg::OP_DEQ) ? deq_band : q_band;
    sel_ptr  = (q_pkt.op == spq_pkg::OP_DEQ) ? head[sel_band] : tail[sel_band];
    ptr_next = (sel_ptr == PW'(RING_DEPTH - 1)) ? '0 : sel_ptr + 1'b1;
    addr     = AW'(sel_band) * AW'(RING_DEPTH) + AW'(sel_ptr);
    limit    = cfg.priority_mode ? SW'(cfg.byte_limit)
                                 : SW'({cfg.byte_limit, {spq_pkg::FIFO_SHIFT{1'b0}}});
    tot_sum  = SW'(total_bytes) + SW'(q_pkt.bytes);
    band_sum = SW'(band_bytes[sel_band]) + SW'(q_pkt.bytes);
    pk_inc   = EW'(total_packets) + EW'(1);
    eval_ecn = 1'b0;
    if (q_pkt.op == spq_pkg::OP_DEQ) begin
      eval_status = deq_any ? spq_pkg::ST_DEQUEUED : spq_pkg::ST_EMPTY;
    end else begin
      priority if (tot_sum > limit) begin
        eval_status = spq_pkg::ST_TOTAL_DROP;
      end else if (cfg.priority_mode && (band_sum > SW'(cfg.byte_limit))) begin
        eval_status = spq_pkg::ST_BAND_DROP;
      end else if (count[sel_band] == CW'(RING_DEPTH)) begin
        eval_status = spq_pkg::ST_RING_FULL;
      end else begin
        eval_status = spq_pkg::ST_ENQUEUED;
        eval_ecn    = (pk_inc >= EW'(cfg.mark_threshold));
      end
    end
  end

  assign q_ready   = (state == S_EVAL);
  assign commit_go = (state == S_COMMIT) && (!out_valid || out_ready);
  assign enq_ok    = (w_op == spq_pkg::OP_ENQ) && (w_status == spq_pkg::ST_ENQUEUED);
  assign deq_ok    = (w_op == spq_pkg::OP_DEQ) && (w_status == spq_pkg::ST_DEQUEUED);
  assign rd_bytes  = rd_data[spq_pkg::BYTES_W-1:0];
  assign rd_tag    = rd_data[DW-1:spq_pkg::BYTES_W];

  always_ff @(posedge clk) begin
    if (commit_go && enq_ok) begin
      store[w_addr] <= {w_tag, w_bytes};
    end
    if (q_valid && q_ready && (q_pkt.op == spq_pkg::OP_DEQ)) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_EVAL;
      out_valid     <= 1'b0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      band_bytes    <= '0;
      total_bytes   <= '0;
      total_packets <= '0;
    end else begin
      if (out_valid && out_ready && !commit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_EVAL: begin
          if (q_valid) begin
            w_op         <= q_pkt.op;
            w_tag        <= q_pkt.tag;
            w_bytes      <= q_pkt.bytes;
            w_band       <= sel_band;
            w_status     <= eval_status;
            w_ecn        <= eval_ecn;
            w_addr       <= addr;
            w_ptr_next   <= ptr_next;
            w_count      <= count[sel_band];
            w_band_bytes <= band_bytes[sel_band];
            w_tot_sum    <= tot_sum;
            w_band_sum   <= band_sum;
            state        <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            if (enq_ok) begin
              tail[w_band]       <= w_ptr_next;
              count[w_band]      <= w_count + 1'b1;
              band_bytes[w_band] <= w_band_sum[spq_pkg::TOTAL_W-1:0];
              total_bytes        <= w_tot_sum[spq_pkg::TOTAL_W-1:0];
              total_packets      <= total_packets + 1'b1;
            end else if (deq_ok) begin
              head[w_band]       <= w_ptr_next;
              count[w_band]      <= w_count - 1'b1;
              band_bytes[w_band] <= w_band_bytes - spq_pkg::TOTAL_W'(rd_bytes);
              total_bytes        <= total_bytes - spq_pkg::TOTAL_W'(rd_bytes);
              total_packets      <= total_packets - 1'b1;
            end
            out_valid  <= 1'b1;
            status     <= w_status;
            ecn_marked <= w_ecn;
            out_tag    <= deq_ok ? rd_tag : '0;
            out_bytes  <= deq_ok ? rd_bytes : '0;
            out_band   <= spq_pkg::OUT_BAND_W'(w_band);
            state      <= S_EVAL;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/strict_priority_packet_queue_core.sv
// Top level of the strict-priority packet queue: register port, input stage, queue and execution.
//
// Each item is one enqueue or one dequeue and gives one result. The execution stage first
// classifies an item against the band counters and byte limits (and reads the head descriptor
// for a dequeue) and then, in its commit state, commits the update and loads the result
// register; the commit waits while an earlier result is still untaken, and no new item is
// taken until it is done. A result passes the input register, the queue, the classify state
// and the commit state before it is presented. An input register and a two-entry queue let new
// items be taken while the execution stage works or while a result waits to be taken. The
// descriptor store is a single memory of BANDS * RING_DEPTH entries and needs no clearing after
// reset. Registers at byte addresses 0, 4 and 8 hold the mode, byte limit and mark threshold;
// they are to be written only while the block is idle.
`include "strict_priority_packet_queue_core_defines.svh"

module strict_priority_packet_queue_core #(
  parameter int BANDS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spq_pkg::ADDR_W-1:0]     paddr,
  input  logic [spq_pkg::DATA_W-1:0]     pwdata,
  output logic [spq_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [spq_pkg::TAG_W-1:0]      packet_tag,
  input  logic [spq_pkg::BYTES_W-1:0]    packet_bytes,
  input  logic [spq_pkg::PRI_W-1:0]      pkt_prio,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output logic                           ecn_marked,
  output logic [spq_pkg::TAG_W-1:0]      out_tag,
  output logic [spq_pkg::BYTES_W-1:0]    out_bytes,
  output logic [spq_pkg::OUT_BAND_W-1:0] out_band
);

  localparam int BW = $clog2(BANDS);
  localparam int QW = $bits(spq_pkg::pkt_t) + BW;

  spq_pkg::cfg_t    cfg;
  spq_pkg::reg_idx_t reg_idx;

  logic              f_valid;
  logic              f_ready;
  spq_pkg::pkt_t     f_pkt;
  logic [BW-1:0]     f_band;
  logic              q_valid;
  logic              q_ready;
  logic [QW-1:0]     q_data;
  spq_pkg::status_t  b_status;

  assign pready  = 1'b1;
  assign reg_idx = spq_pkg::reg_idx_t'(paddr[spq_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.priority_mode  <= spq_pkg::MODE_RESET;
      cfg.byte_limit     <= spq_pkg::LIMIT_RESET;
      cfg.mark_threshold <= spq_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        spq_pkg::REG_MODE:   cfg.priority_mode  <= pwdata[0];
        spq_pkg::REG_LIMIT:  cfg.byte_limit     <= pwdata[spq_pkg::LIMIT_W-1:0];
        spq_pkg::REG_THRESH: cfg.mark_threshold <= pwdata[spq_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      spq_pkg::REG_MODE:   prdata = spq_pkg::DATA_W'(cfg.priority_mode);
      spq_pkg::REG_LIMIT:  prdata = spq_pkg::DATA_W'(cfg.byte_limit);
      spq_pkg::REG_THRESH: prdata = spq_pkg::DATA_W'(cfg.mark_threshold);
      default:             prdata = '0;
    endcase
  end

  spq_front #(
    .BANDS(BANDS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .packet_tag     (packet_tag),
    .packet_bytes   (packet_bytes),
    .pkt_prio       (pkt_prio),
    .push_valid     (f_valid),
    .push_ready     (f_ready),
    .push_pkt       (f_pkt),
    .push_band      (f_band)
  );

  spq_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_pkt, f_band}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  spq_back #(
    .BANDS     (BANDS),
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_pkt     (spq_pkg::pkt_t'(q_data[QW-1:BW])),
    .q_band    (q_data[BW-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (b_status),
    .ecn_marked(ecn_marked),
    .out_tag   (out_tag),
    .out_bytes (out_bytes),
    .out_band  (out_band)
  );

  assign status = b_status;

  `SPQ_ASSERT_IMP(a_no_payload_unless_dequeued,
                  out_valid && (status != spq_pkg::ST_DEQUEUED),
                  (out_tag == '0) && (out_bytes == '0), "payload on a non-dequeue result")
  `SPQ_ASSERT_IMP(a_empty_reports_band0, out_valid && (status == spq_pkg::ST_EMPTY),
                  out_band == '0, "empty dequeue reports a nonzero band")
  `SPQ_ASSERT_IMP(a_mark_only_on_enqueue, out_valid && ecn_marked,
                  status == spq_pkg::ST_ENQUEUED, "ECN mark on a result that is not an enqueue")
  `SPQ_ASSERT_NEXT(a_front_holds_transfer, in_valid && in_ready, f_valid,
                   "input transfer not held by the input stage")

endmodule

FILE: verif/strict_priority_packet_queue_core_tb.sv
// Self-checking testbench for the strict-priority packet queue core, with its own queue predictor.
module strict_priority_packet_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BANDS   = 8;
  localparam int RING_SLOTS  = 256;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    spq_pkg::status_t            st;
    logic                        ecn;
    logic [spq_pkg::TAG_W-1:0]   tag;
    logic [spq_pkg::BYTES_W-1:0] nbytes;
    logic [2:0]                  band;
  } outcome_t;

  class spq_scoreboard;
    logic                         mode;
    logic [spq_pkg::LIMIT_W-1:0]  limit;
    logic [spq_pkg::THRESH_W-1:0] thresh;
    logic [spq_pkg::TAG_W-1:0]    slot_tag   [NUM_BANDS][RING_SLOTS];
    logic [spq_pkg::BYTES_W-1:0]  slot_bytes [NUM_BANDS][RING_SLOTS];
    int                           head  [NUM_BANDS];
    int                           tail  [NUM_BANDS];
    int                           count [NUM_BANDS];
    longint                       band_sum [NUM_BANDS];
    longint                       total_sum;
    int                           total_pkts;
    outcome_t                     due[$];
    int                           errors;

    function new();
      mode   = spq_pkg::MODE_RESET;
      limit  = spq_pkg::LIMIT_RESET;
      thresh = spq_pkg::THRESH_RESET;
      for (int b = 0; b < NUM_BANDS; b++) begin
        head[b]     = 0;
        tail[b]     = 0;
        count[b]    = 0;
        band_sum[b] = 0;
      end
      total_sum  = 0;
      total_pkts = 0;
      errors     = 0;
    endfunction

    function void write_reg(spq_pkg::reg_idx_t idx, logic [spq_pkg::DATA_W-1:0] val);
      case (idx)
        spq_pkg::REG_MODE:   mode   = val[0];
        spq_pkg::REG_LIMIT:  limit  = val[spq_pkg::LIMIT_W-1:0];
        spq_pkg::REG_THRESH: thresh = val[spq_pkg::THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(spq_pkg::op_t op, logic [spq_pkg::TAG_W-1:0] tag,
                            logic [spq_pkg::BYTES_W-1:0] nb, logic [spq_pkg::PRI_W-1:0] pri);
      outcome_t o;
      int       b;
      longint   cap;
      o.st     = spq_pkg::ST_EMPTY;
      o.ecn    = 1'b0;
      o.tag    = '0;
      o.nbytes = '0;
      o.band   = '0;
      if (op == spq_pkg::OP_ENQ) begin
        b = 0;
        if (mode) begin
          b = (pri == 0) ? 0 : int'(pri) - 1;
          if (b > NUM_BANDS - 1) b = NUM_BANDS - 1;
          cap = limit;
        end else begin
          cap = longint'(limit) * 8;
        end
        o.band = b[2:0];
        if (total_sum + nb > cap) begin
          o.st = spq_pkg::ST_TOTAL_DROP;
        end else if (mode && band_sum[b] + nb > limit) begin
          o.st = spq_pkg::ST_BAND_DROP;
        end else if (count[b] >= RING_SLOTS) begin
          o.st = spq_pkg::ST_RING_FULL;
        end else begin
          slot_tag[b][tail[b]]   = tag;
          slot_bytes[b][tail[b]] = nb;
          tail[b]     = (tail[b] + 1) % RING_SLOTS;
          count[b]    = count[b] + 1;
          band_sum[b] = band_sum[b] + nb;
          total_sum   = total_sum + nb;
          total_pkts  = total_pkts + 1;
          o.st  = spq_pkg::ST_ENQUEUED;
          o.ecn = (total_pkts >= thresh);
        end
      end else begin
        for (int i = 0; i < NUM_BANDS; i++) begin
          if (count[i] != 0 && o.st == spq_pkg::ST_EMPTY) begin
            o.st        = spq_pkg::ST_DEQUEUED;
            o.tag       = slot_tag[i][head[i]];
            o.nbytes    = slot_bytes[i][head[i]];
            o.band      = i[2:0];
            head[i]     = (head[i] + 1) % RING_SLOTS;
            count[i]    = count[i] - 1;
            band_sum[i] = band_sum[i] - o.nbytes;
            total_sum   = total_sum - o.nbytes;
            total_pkts  = total_pkts - 1;
          end
        end
      end
      due.insert(due.size(), o);
    endfunction

    function void match_result(logic [spq_pkg::STATUS_W-1:0] st, logic ecn,
                               logic [spq_pkg::TAG_W-1:0] tag,
                               logic [spq_pkg::BYTES_W-1:0] nb,
                               logic [spq_pkg::OUT_BAND_W-1:0] band);
      outcome_t o;
      if (due.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, st);
        errors++;
        return;
      end
      o = due[0];
      due.delete(0);
      if (st !== o.st) begin
        $display("%0t: status expected %0d, got %0d", $time, o.st, st);
        errors++;
      end
      if (ecn !== o.ecn) begin
        $display("%0t: ecn_marked expected %0d, got %0d", $time, o.ecn, ecn);
        errors++;
      end
      if (tag !== o.tag) begin
        $display("%0t: out_tag expected %h, got %h", $time, o.tag, tag);
        errors++;
      end
      if (nb !== o.nbytes) begin
        $display("%0t: out_bytes expected %0d, got %0d", $time, o.nbytes, nb);
        errors++;
      end
      if (band !== o.band) begin
        $display("%0t: out_band expected %0d, got %0d", $time, o.band, band);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [spq_pkg::ADDR_W-1:0]     paddr = '0;
  logic [spq_pkg::DATA_W-1:0]     pwdata = '0;
  logic [spq_pkg::DATA_W-1:0]     prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           opcode = 1'b0;
  logic [spq_pkg::TAG_W-1:0]      packet_tag = '0;
  logic [spq_pkg::BYTES_W-1:0]    packet_bytes = '0;
  logic [spq_pkg::PRI_W-1:0]      pkt_prio = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic                           ecn_marked;
  logic [spq_pkg::TAG_W-1:0]      out_tag;
  logic [spq_pkg::BYTES_W-1:0]    out_bytes;
  logic [spq_pkg::OUT_BAND_W-1:0] out_band;

  spq_scoreboard sb;
  bit            steady = 1'b0;
  int            stall_left = 0;
  int            cycles = 0;

  strict_priority_packet_queue_core #(
    .BANDS      (NUM_BANDS),
    .RING_DEPTH (RING_SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .packet_tag      (packet_tag),
    .packet_bytes    (packet_bytes),
    .pkt_prio        (pkt_prio),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .ecn_marked      (ecn_marked),
    .out_tag         (out_tag),
    .out_bytes       (out_bytes),
    .out_band        (out_band)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [spq_pkg::BYTES_W-1:0] pick_bytes(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      1: return spq_pkg::BYTES_W'($urandom_range(0, 2));
      2: return (r < 3) ? '0 : spq_pkg::BYTES_W'($urandom_range(1, 64));
      default: begin
        if (r < 3) return '0;
        else if (r < 8) return 14'd16383;
        else if (r < 40) return spq_pkg::BYTES_W'($urandom_range(1, 255));
        else return spq_pkg::BYTES_W'($urandom_range(1, 16383));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.match_result(status, ecn_marked, out_tag, out_bytes, out_band);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady) stall_left = pick_gap();
    end
  end

  task automatic send(spq_pkg::op_t op, logic [spq_pkg::TAG_W-1:0] tag,
                      logic [spq_pkg::BYTES_W-1:0] nb, logic [spq_pkg::PRI_W-1:0] pri);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    packet_tag   <= tag;
    packet_bytes <= nb;
    pkt_prio     <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(op, tag, nb, pri);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(spq_pkg::reg_idx_t idx, logic [spq_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= spq_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic m, logic [spq_pkg::LIMIT_W-1:0] lim,
                           logic [spq_pkg::THRESH_W-1:0] th);
    wait_idle();
    reg_write(spq_pkg::REG_MODE, spq_pkg::DATA_W'(m));
    reg_write(spq_pkg::REG_LIMIT, spq_pkg::DATA_W'(lim));
    reg_write(spq_pkg::REG_THRESH, spq_pkg::DATA_W'(th));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(int items, int enq_pct, int bias, int kind);
    spq_pkg::op_t              op;
    logic [spq_pkg::PRI_W-1:0] pri;
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      op  = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      pri = (bias >= 0 && $urandom_range(0, 3) != 0) ? spq_pkg::PRI_W'(bias)
                                                     : spq_pkg::PRI_W'($urandom_range(0, 15));
      send(op, spq_pkg::TAG_W'($urandom()), pick_bytes(kind), pri);
    end
  endtask

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty dequeue, field extremes, every priority, zero size and a total drop.
    send(spq_pkg::OP_DEQ, 16'h1234, 14'd5, 4'd3);
    send(spq_pkg::OP_ENQ, 16'h0000, 14'd1, 4'd0);
    send(spq_pkg::OP_ENQ, 16'hFFFF, 14'd16383, 4'd1);
    for (int p = 2; p < 16; p++) begin
      send(spq_pkg::OP_ENQ, spq_pkg::TAG_W'(p * 16'h1111), spq_pkg::BYTES_W'(p * 3),
           spq_pkg::PRI_W'(p));
    end
    send(spq_pkg::OP_ENQ, 16'hA5A5, 14'd0, 4'd4);
    send(spq_pkg::OP_ENQ, 16'h5A5A, 14'd16383, 4'd8);
    send(spq_pkg::OP_ENQ, 16'h0F0F, 14'd16383, 4'd6);
    repeat (3) send(spq_pkg::OP_DEQ, 16'h0000, 14'd0, 4'd0);

    configure(1'b1, spq_pkg::LIMIT_W'($urandom_range(20000, 60000)),
              spq_pkg::THRESH_W'($urandom_range(0, 30)));
    run_phase(250, 55, -1, 0);
    configure(1'b1, 24'd1, 12'd0);
    run_phase(150, 60, -1, 1);
    configure(1'b1, 24'hFFFFFF, 12'd2048);
    run_phase(350, 90, $urandom_range(0, 15), 2);
    configure(1'b0, spq_pkg::LIMIT_W'($urandom_range(1000, 4000)),
              spq_pkg::THRESH_W'($urandom_range(1, 40)));
    run_phase(300, 60, -1, 0);
    configure(1'b0, 24'hFFFFFF, spq_pkg::THRESH_W'($urandom_range(0, 2048)));
    run_phase(200, 60, -1, 2);
    configure(1'b1, 24'd36000, 12'd22);
    run_phase(250, 25, -1, 0);
    while (sb.total_pkts > 0) begin
      send(spq_pkg::OP_DEQ, spq_pkg::TAG_W'($urandom()), pick_bytes(0), 4'd0);
    end
    send(spq_pkg::OP_DEQ, 16'hFFFF, 14'd16383, 4'd15);

    wait_idle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_fifo.sv
rtl/spq_back.sv
rtl/strict_priority_packet_queue_core.sv
verif/strict_priority_packet_queue_core_tb.sv
